>>> hdl/hsn_pkg.sv
// ============================================================================
// hsn_pkg: shared types and constants for the HDLC stuffing NRZI encoder
// Holds the run length, derived widths and the line-bit command record.
// ============================================================================
`default_nettype none

package hsn_pkg;

    localparam int RUN_LENGTH    = 5;
    localparam int BYTE_W        = 8;
    localparam int PAD_W         = 3;

    // Line bits one data byte can produce: eight data levels plus stuff levels.
    // Worst case: a run one short of RUN_LENGTH carries in from the last byte.
    localparam int MAX_LINE_BITS = BYTE_W + (BYTE_W - 1 + RUN_LENGTH) / RUN_LENGTH;
    localparam int LINE_CNT_W    = $clog2(MAX_LINE_BITS + 1);
    localparam int LINE_IDX_W    = $clog2(MAX_LINE_BITS);

    // Back-end accumulator: up to seven pending levels plus one byte's line bits.
    localparam int ACC_W         = (BYTE_W - 1) + MAX_LINE_BITS;
    localparam int ACC_CNT_W     = $clog2(ACC_W + 1);

    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

    typedef struct packed {
        logic [MAX_LINE_BITS-1:0] bits;   // line levels, first in bit 0, unused bits zero
        logic [LINE_CNT_W-1:0]    nbits;  // number of valid line levels
        logic                     start;  // drop pending levels before these
        logic                     fin;    // flush pending levels after these
    } t_cmd;

endpackage

`default_nettype wire

>>> hdl/hdlc_stuff_nrzi_encoder_top.sv
// ============================================================================
// hdlc_stuff_nrzi_encoder_top: HDLC bit-stuffing NRZI line encoder
// Encodes data bytes LSB first into NRZI line levels with zero stuffing and
// packs the levels into output bytes, with frame start and frame end marks.
// ============================================================================
//
//  Channel | Handshake      | Payload                                     | Dir
//  --------+----------------+---------------------------------------------+----
//  input   | push / full    | i_data_byte, i_stuff_enable,                 | in
//          |                | i_frame_start, i_frame_end                   |
//  result  | empty / pop    | o_out_byte, o_pad_bits, o_frame_last         | out
//
//  A beat is taken while full is low; the front end settles level, ones run
//  and all line levels of the byte in that cycle and queues them.
//  The back end sends one output beat per cycle while the result side is not
//  stalled: one per output byte a command completes, plus a frame flush.
//  A two-entry command queue sits between the two; full rises when it fills,
//  either behind a stalled result side or when bytes arrive faster than the
//  packer retires them, as for a byte that completes several beats.
//  Synchronous active-low reset: level 1, ones run and packer cleared.
//
`default_nettype none

module hdlc_stuff_nrzi_encoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_stuff_enable,
    input  wire logic       i_frame_start,
    input  wire logic       i_frame_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_pad_bits,
    output logic            o_frame_last
);

    hsn_pkg::t_cmd front_cmd;
    hsn_pkg::t_cmd q_cmd;
    logic          in_fire;
    logic          q_valid;
    logic          q_pop;

    // Take a beat only when the queue has room for its command.
    assign in_fire = push && !full;

    // Front end: NRZI toggle, ones counting and stuff insertion.
    hsn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_fire),
        .i_data_byte    (i_data_byte),
        .i_stuff_enable (i_stuff_enable),
        .i_frame_start  (i_frame_start),
        .i_frame_end    (i_frame_end),
        .o_cmd          (front_cmd)
    );

    // Hold line-bit commands while the packer drains.
    hsn_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back end: pack, emit one beat per cycle while the result slot is free, flush at frame end.
    hsn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_byte   (o_out_byte),
        .o_pad_bits   (o_pad_bits),
        .o_frame_last (o_frame_last)
    );

    // An accepted beat always lands a command in the queue.
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> q_valid)
        else $error("accepted beat did not reach the command queue");

    // Every byte makes at least eight and at most the maximum line levels.
    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (front_cmd.nbits >= hsn_pkg::LINE_CNT_W'(hsn_pkg::BYTE_W)) &&
                    (front_cmd.nbits <= hsn_pkg::LINE_CNT_W'(hsn_pkg::MAX_LINE_BITS)))
        else $error("line level count out of range");

    // Padding only ever appears on the closing byte of a frame.
    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_pad_bits != 3'd0)) |-> o_frame_last)
        else $error("pad bits on a byte that does not close a frame");

endmodule

`default_nettype wire

>>> hdl/hsn_front.sv
// ============================================================================
// hsn_front: NRZI and bit-stuffing front end
// Turns one data byte into a run of line levels and tracks level and ones run.
// ============================================================================
`default_nettype none

module hsn_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_stuff_enable,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_frame_end,
    output hsn_pkg::t_cmd             o_cmd
);

    logic                              r_level;
    logic [2:0]                        r_ones;
    logic                              n_level;
    logic [2:0]                        n_ones;
    logic [hsn_pkg::MAX_LINE_BITS-1:0] line_bits;
    logic [hsn_pkg::LINE_CNT_W-1:0]    line_cnt;

    // Walk the byte LSB first; insert a toggled level after a full run of ones when stuffing is enabled.
    always_comb begin
        n_level   = i_frame_start ? 1'b1 : r_level;
        n_ones    = i_frame_start ? 3'd0 : r_ones;
        line_bits = '0;
        line_cnt  = '0;
        for (int i = 0; i < hsn_pkg::BYTE_W; i++) begin
            if (!i_data_byte[i]) begin
                n_level = ~n_level;
                n_ones  = 3'd0;
            end else begin
                n_ones  = n_ones + 3'd1;
            end
            line_bits[line_cnt[hsn_pkg::LINE_IDX_W-1:0]] = n_level;
            line_cnt = line_cnt + hsn_pkg::LINE_CNT_W'(1);
            if (n_ones >= 3'(hsn_pkg::RUN_LENGTH)) begin
                if (i_stuff_enable) begin
                    n_level = ~n_level;
                    line_bits[line_cnt[hsn_pkg::LINE_IDX_W-1:0]] = n_level;
                    line_cnt = line_cnt + hsn_pkg::LINE_CNT_W'(1);
                end
                n_ones = 3'd0;
            end
        end
    end

    always_comb begin
        o_cmd.bits  = line_bits;
        o_cmd.nbits = line_cnt;
        o_cmd.start = i_frame_start;
        o_cmd.fin   = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_ones  <= 3'd0;
        end else if (i_accept) begin
            r_level <= n_level;
            r_ones  <= n_ones;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hsn_cmd_fifo.sv
// ============================================================================
// hsn_cmd_fifo: short command queue between front and back end
// Holds line-bit commands so either side can stall on its own.
// ============================================================================
`default_nettype none

module hsn_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hsn_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output hsn_pkg::t_cmd      o_cmd
);

    hsn_pkg::t_cmd                 mem [hsn_pkg::CMD_DEPTH];
    logic [hsn_pkg::CMD_PTR_W-1:0] r_wr_ptr;
    logic [hsn_pkg::CMD_PTR_W-1:0] r_rd_ptr;
    logic [hsn_pkg::CMD_CNT_W-1:0] r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == hsn_pkg::CMD_CNT_W'(hsn_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + hsn_pkg::CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + hsn_pkg::CMD_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + hsn_pkg::CMD_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - hsn_pkg::CMD_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/hsn_back.sv
// ============================================================================
// hsn_back: byte packer back end
// Packs line levels into output bytes, one beat a cycle while the output slot is free, and flushes frames.
// ============================================================================
`default_nettype none

module hsn_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire hsn_pkg::t_cmd i_cmd,
    output logic               o_q_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_out_byte,
    output logic [2:0]         o_pad_bits,
    output logic               o_frame_last
);

    localparam int AW = hsn_pkg::ACC_W;
    localparam int CW = hsn_pkg::ACC_CNT_W;

    logic [AW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_fin;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [2:0]    r_out_pad;
    logic          r_out_last;

    logic          full_byte;
    logic          flush;
    logic          can_emit;
    logic          slot_free;
    logic          emit;
    logic [AW-1:0] rem_acc;
    logic [CW-1:0] rem_cnt;
    logic          rem_done;
    logic          load;
    logic [AW-1:0] base_acc;
    logic [2:0]    base_cnt;
    logic [AW-1:0] n_acc;
    logic [CW-1:0] n_cnt;
    logic          n_fin;
    logic [2:0]    emit_pad;
    logic          emit_last;

    always_comb begin
        full_byte = (r_cnt >= CW'(hsn_pkg::BYTE_W));
        flush     = r_fin && (r_cnt != '0) && !full_byte;
        can_emit  = full_byte || flush;
        slot_free = !r_out_valid || i_pop;
        emit      = can_emit && slot_free;

        emit_pad  = full_byte ? 3'd0 : 3'(CW'(hsn_pkg::BYTE_W) - r_cnt);
        emit_last = full_byte ? (r_fin && (r_cnt == CW'(hsn_pkg::BYTE_W))) : 1'b1;

        // Retire the emitted byte; a flushed partial byte leaves nothing.
        if (emit) begin
            rem_acc = r_acc >> hsn_pkg::BYTE_W;
            rem_cnt = full_byte ? (r_cnt - CW'(hsn_pkg::BYTE_W)) : '0;
        end else begin
            rem_acc = r_acc;
            rem_cnt = r_cnt;
        end
        rem_done = (rem_cnt < CW'(hsn_pkg::BYTE_W)) && !(r_fin && (rem_cnt != '0));

        // Merge the next command's line levels behind what is left, or in its place on a frame start.
        load     = rem_done && i_q_valid;
        base_acc = i_cmd.start ? '0 : rem_acc;
        base_cnt = i_cmd.start ? 3'd0 : rem_cnt[2:0];

        if (load) begin
            n_acc = base_acc | (AW'(i_cmd.bits) << base_cnt);
            n_cnt = CW'(base_cnt) + CW'(i_cmd.nbits);
            n_fin = i_cmd.fin;
        end else begin
            n_acc = rem_acc;
            n_cnt = rem_cnt;
            n_fin = rem_done ? 1'b0 : r_fin;
        end
    end

    assign o_q_pop      = load;
    assign o_empty      = !r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_pad_bits   = r_out_pad;
    assign o_frame_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_fin <= n_fin;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= r_acc[7:0];
            r_out_pad  <= emit_pad;
            r_out_last <= emit_last;
        end
    end

endmodule

`default_nettype wire
